[rtl/core/asn1_token_scanner_top_macros.svh]
// Assertion macros for the token scanner.
`ifndef ASN1_TOKEN_SCANNER_TOP_MACROS_SVH
`define ASN1_TOKEN_SCANNER_TOP_MACROS_SVH

// Check that an implication holds at every clock edge outside reset.
`define ATS_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Check that an implication holds in the cycle after its trigger.
`define ATS_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

[rtl/core/ats_pkg.sv]
// -----------------------------------------------------------------------------
// ats_pkg
// Shared types, kind codes and the keyword table of the token scanner.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ats_pkg;

   localparam int MaxWordLenDefault = 16;
   localparam int LineBitsDefault   = 24;
   localparam int ColumnBitsDefault = 16;

   localparam int KwCount  = 42;
   localparam int KwMaxLen = 15;
   localparam int KindBits = 7;
   localparam int OutLineBits = 24;
   localparam int OutColBits  = 16;
   localparam int LenBits     = 16;

   typedef enum logic [3:0] {
      MODE_IDLE    = 4'd0,
      MODE_IDENT   = 4'd1,
      MODE_NUMBER  = 4'd2,
      MODE_STRING  = 4'd3,
      MODE_COMMENT = 4'd4,
      MODE_DASH    = 4'd5,
      MODE_LBRACK  = 4'd6,
      MODE_RBRACK  = 4'd7,
      MODE_DOT1    = 4'd8,
      MODE_DOT2    = 4'd9,
      MODE_COLON1  = 4'd10,
      MODE_COLON2  = 4'd11
   } mode_type;

   localparam logic [6:0] KIND_EOF    = 7'd0;
   localparam logic [6:0] KIND_IDENT  = 7'd1;
   localparam logic [6:0] KIND_NUMBER = 7'd2;
   localparam logic [6:0] KIND_STRING = 7'd3;
   localparam logic [6:0] KIND_UNKNOWN = 7'd4;
   localparam logic [6:0] KIND_LPAREN = 7'd5;
   localparam logic [6:0] KIND_RPAREN = 7'd6;
   localparam logic [6:0] KIND_LBRACE = 7'd7;
   localparam logic [6:0] KIND_RBRACE = 7'd8;
   localparam logic [6:0] KIND_DLBRACK = 7'd9;
   localparam logic [6:0] KIND_LBRACK = 7'd10;
   localparam logic [6:0] KIND_DRBRACK = 7'd11;
   localparam logic [6:0] KIND_RBRACK = 7'd12;
   localparam logic [6:0] KIND_COMMA  = 7'd13;
   localparam logic [6:0] KIND_ELLIPSIS = 7'd14;
   localparam logic [6:0] KIND_RANGE  = 7'd15;
   localparam logic [6:0] KIND_DOT    = 7'd16;
   localparam logic [6:0] KIND_BAR    = 7'd17;
   localparam logic [6:0] KIND_MINUS  = 7'd18;
   localparam logic [6:0] KIND_AMP    = 7'd19;
   localparam logic [6:0] KIND_AT     = 7'd20;
   localparam logic [6:0] KIND_SEMI   = 7'd21;
   localparam logic [6:0] KIND_PLUS   = 7'd22;
   localparam logic [6:0] KIND_ASSIGN = 7'd23;
   localparam logic [6:0] KIND_KW_BASE = 7'd24;

   typedef logic [KwMaxLen*8-1:0] kw_text_type;

   // keyword text, first character in the low byte
   function automatic kw_text_type kw_text(input int idx);
      string s;
      kw_text_type t;
      case (idx)
         0: s = "SEQUENCE";       1: s = "SET";           2: s = "CHOICE";
         3: s = "OPTIONAL";       4: s = "DEFAULT";       5: s = "INTEGER";
         6: s = "BOOLEAN";        7: s = "ENUMERATED";    8: s = "OCTET";
         9: s = "BIT";            10: s = "SIZE";         11: s = "OF";
         12: s = "OBJECT";        13: s = "DEFINITIONS";  14: s = "BEGIN";
         15: s = "END";           16: s = "IMPORTS";      17: s = "FROM";
         18: s = "ANY";           19: s = "DEFINED";      20: s = "BY";
         21: s = "CLASS";         22: s = "CONTAINING";   23: s = "WITH";
         24: s = "COMPONENTS";    25: s = "IMPLICIT";     26: s = "EXPLICIT";
         27: s = "APPLICATION";   28: s = "UNIVERSAL";    29: s = "PRIVATE";
         30: s = "SYNTAX";        31: s = "NULL";         32: s = "REAL";
         33: s = "UTF8String";    34: s = "PrintableString";
         35: s = "VisibleString"; 36: s = "IA5String";    37: s = "NumericString";
         38: s = "AUTOMATIC";     39: s = "TAGS";         40: s = "EXTENSIBILITY";
         default: s = "IMPLIED";
      endcase
      t = '0;
      for (int k = 0; k < KwMaxLen; k++) begin
         if (k < s.len()) t[k*8 +: 8] = s[k];
      end
      return t;
   endfunction

   function automatic int kw_len(input int idx);
      kw_text_type t;
      int n;
      t = kw_text(idx);
      n = 0;
      for (int k = 0; k < KwMaxLen; k++) begin
         if (t[k*8 +: 8] != 8'd0) n = k + 1;
      end
      return n;
   endfunction

   typedef struct packed {
      logic [6:0]  kind;
      logic [23:0] line;
      logic [15:0] column;
      logic [15:0] length;
      logic [7:0]  first;
   } token_type;

endpackage

[rtl/core/ats_kw_match.sv]
// -----------------------------------------------------------------------------
// ats_kw_match
// Parallel compare of the buffered word against the keyword table.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ats_kw_match #(
   parameter int MAX_WORD_LEN = ats_pkg::MaxWordLenDefault
) (
   input  logic [ats_pkg::KwMaxLen*8-1:0] word_text,
   input  logic [ats_pkg::LenBits-1:0]    word_len,
   output logic [ats_pkg::KindBits-1:0]   word_kind
);
   import ats_pkg::*;

   always_comb begin
      word_kind = KIND_IDENT;
      if (word_len <= LenBits'(MAX_WORD_LEN)) begin
         for (int i = 0; i < KwCount; i++) begin
            if (word_len == LenBits'(kw_len(i))
                  && (word_text & ((KwMaxLen*8)'(1) << (kw_len(i)*8)) - 1'b1)
                     == kw_text(i)) begin
               word_kind = KIND_KW_BASE + KindBits'(i);
            end
         end
      end
   end

endmodule

[rtl/core/ats_out_queue.sv]
// -----------------------------------------------------------------------------
// ats_out_queue
// Four-entry result queue that parts the scanner from the receiver.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ats_out_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push0,
   input  logic                  push1,
   input  ats_pkg::token_type    tok0,
   input  ats_pkg::token_type    tok1,
   input  logic                  last0,
   output logic                  space2,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output ats_pkg::token_type    rsp_tok,
   output logic                  rsp_last
);
   import ats_pkg::*;

   token_type   data_ff [4];
   logic        last_ff [4];
   logic [1:0]  rd_ff, wr_ff;
   logic [2:0]  cnt_ff;
   logic        pop;
   logic [2:0]  cnt_in;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = cnt_ff != 3'd0;
   assign rsp_tok    = data_ff[rd_ff];
   assign rsp_last   = last_ff[rd_ff];
   assign space2     = cnt_ff <= 3'd2;
   assign cnt_in     = cnt_ff + 3'(push0) + 3'(push1) - 3'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (pop) rd_ff <= rd_ff + 2'd1;
         wr_ff  <= wr_ff + 2'(push0) + 2'(push1);
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         data_ff[wr_ff] <= tok0;
         last_ff[wr_ff] <= last0;
      end
      if (push1) begin
         data_ff[wr_ff + 2'd1] <= tok1;
         last_ff[wr_ff + 2'd1] <= 1'b1;
      end
   end

endmodule

[rtl/core/ats_scan_core.sv]
// -----------------------------------------------------------------------------
// ats_scan_core
// Scanner state, position counters and per-byte token decisions.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ats_scan_core #(
   parameter int MAX_WORD_LEN = ats_pkg::MaxWordLenDefault,
   parameter int LINE_BITS    = ats_pkg::LineBitsDefault,
   parameter int COLUMN_BITS  = ats_pkg::ColumnBitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          char_byte,
   input  logic                end_of_input,
   output logic                emit0,
   output logic                emit1,
   output ats_pkg::token_type  tok0,
   output ats_pkg::token_type  tok1
);
   import ats_pkg::*;
   `include "asn1_token_scanner_top_macros.svh"

   localparam int WIDX = $clog2(MAX_WORD_LEN);
   localparam logic [LINE_BITS-1:0]   LineTop = '1;
   localparam logic [COLUMN_BITS-1:0] ColTop  = '1;

   mode_type               mode_ff, mode_in;
   logic [LINE_BITS-1:0]   line_ff, line_in, tline_ff, tline_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in, tcol_ff, tcol_in;
   logic [LenBits-1:0]     len_ff, len_in;
   logic [7:0]             first_ff, first_in;
   logic                   quote_ff, quote_in;
   logic [7:0]             word_ff [MAX_WORD_LEN];
   logic                   wr_en;
   logic [KwMaxLen*8-1:0]  word_text;
   logic [KindBits-1:0]    word_kind;
   logic                   eoi, is_sp, is_dg, is_al, flush_go, idle_go, app;
   logic [7:0]             c;
   token_type              ftok, itok;
   logic                   femit, iemit;
   mode_type               imode;

   always_comb begin
      word_text = '0;
      for (int k = 0; k < KwMaxLen; k++) begin
         if (k < MAX_WORD_LEN) word_text[k*8 +: 8] = word_ff[k];
      end
   end

   ats_kw_match #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_kw (
      .word_text(word_text), .word_len(len_ff), .word_kind(word_kind)
   );

   function automatic logic [OutLineBits-1:0] ol(input logic [LINE_BITS-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return w[OutLineBits-1:0];
   endfunction

   function automatic logic [OutColBits-1:0] oc(input logic [COLUMN_BITS-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return w[OutColBits-1:0];
   endfunction

   assign c     = char_byte;
   assign eoi   = end_of_input || (char_byte == 8'd0);
   assign is_sp = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
   assign is_dg = c >= "0" && c <= "9";
   assign is_al = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");

   // pending token as it would flush now
   always_comb begin
      femit = 1'b1;
      ftok  = '{kind: KIND_UNKNOWN, line: ol(tline_ff), column: oc(tcol_ff),
                length: len_ff, first: first_ff};
      case (mode_ff)
         MODE_IDENT:  ftok.kind = word_kind;
         MODE_NUMBER: ftok.kind = KIND_NUMBER;
         MODE_STRING: ftok.kind = KIND_STRING;
         MODE_DASH:   ftok.kind = KIND_MINUS;
         MODE_LBRACK: ftok.kind = KIND_LBRACK;
         MODE_RBRACK: ftok.kind = KIND_RBRACK;
         MODE_DOT1:   ftok.kind = KIND_DOT;
         MODE_DOT2:   ftok.kind = KIND_RANGE;
         MODE_COLON1, MODE_COLON2: ftok.kind = KIND_UNKNOWN;
         default:     femit = 1'b0;
      endcase
   end

   // the byte scanned from idle
   always_comb begin
      iemit = 1'b0;
      imode = MODE_IDLE;
      itok  = '{kind: KIND_UNKNOWN, line: ol(line_ff), column: oc(col_ff),
                length: LenBits'(1), first: c};
      if (is_sp) begin
         imode = MODE_IDLE;
      end else if (is_al || c == "_") begin
         imode = MODE_IDENT;
      end else if (is_dg) begin
         imode = MODE_NUMBER;
      end else if (c == 8'h22 || c == 8'h27) begin
         imode = MODE_STRING;
      end else begin
         case (c)
            "-": imode = MODE_DASH;
            "[": imode = MODE_LBRACK;
            "]": imode = MODE_RBRACK;
            ".": imode = MODE_DOT1;
            ":": imode = MODE_COLON1;
            default: begin
               iemit = 1'b1;
               case (c)
                  "(": itok.kind = KIND_LPAREN;
                  ")": itok.kind = KIND_RPAREN;
                  "{": itok.kind = KIND_LBRACE;
                  "}": itok.kind = KIND_RBRACE;
                  ",": itok.kind = KIND_COMMA;
                  "|": itok.kind = KIND_BAR;
                  "&": itok.kind = KIND_AMP;
                  "@": itok.kind = KIND_AT;
                  ";": itok.kind = KIND_SEMI;
                  "+": itok.kind = KIND_PLUS;
                  default: itok.kind = KIND_UNKNOWN;
               endcase
            end
         endcase
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      tline_in = tline_ff;
      tcol_in  = tcol_ff;
      len_in   = len_ff;
      first_in = first_ff;
      quote_in = quote_ff;
      emit0    = 1'b0;
      emit1    = 1'b0;
      tok0     = ftok;
      tok1     = '{kind: KIND_EOF, line: ol(line_ff), column: oc(col_ff),
                   length: '0, first: '0};
      flush_go = 1'b0;
      idle_go  = 1'b0;
      app      = 1'b0;
      if (eoi) begin
         mode_in = MODE_IDLE;
         if (femit) begin
            emit0 = 1'b1;
            emit1 = 1'b1;
         end else begin
            emit0 = 1'b1;
            tok0  = tok1;
         end
      end else begin
         if (c == 8'h0A) begin
            if (line_ff != LineTop) line_in = line_ff + 1'b1;
            col_in = COLUMN_BITS'(1);
         end else if (col_ff != ColTop) begin
            col_in = col_ff + 1'b1;
         end
         case (mode_ff)
            MODE_IDENT:
               if (is_al || is_dg || c == "_" || c == "-") app = 1'b1;
               else begin flush_go = 1'b1; idle_go = 1'b1; end
            MODE_NUMBER:
               if (is_dg) app = 1'b1;
               else begin flush_go = 1'b1; idle_go = 1'b1; end
            MODE_STRING:
               if (c == (quote_ff ? 8'h27 : 8'h22)) begin
                  flush_go = 1'b1;
                  mode_in  = MODE_IDLE;
               end else app = 1'b1;
            MODE_COMMENT:
               if (c == 8'h0A) mode_in = MODE_IDLE;
            MODE_DASH:
               if (c == "-") mode_in = MODE_COMMENT;
               else begin flush_go = 1'b1; idle_go = 1'b1; end
            MODE_LBRACK, MODE_RBRACK:
               if (c == ((mode_ff == MODE_LBRACK) ? 8'h5B : 8'h5D)) begin
                  emit0     = 1'b1;
                  tok0.kind = (mode_ff == MODE_LBRACK) ? KIND_DLBRACK : KIND_DRBRACK;
                  tok0.length = LenBits'(2);
                  tok0.first  = c;
                  mode_in   = MODE_IDLE;
               end else begin flush_go = 1'b1; idle_go = 1'b1; end
            MODE_DOT1:
               if (c == ".") begin mode_in = MODE_DOT2; len_in = LenBits'(2); end
               else begin flush_go = 1'b1; idle_go = 1'b1; end
            MODE_DOT2:
               if (c == ".") begin
                  emit0 = 1'b1;
                  tok0.kind = KIND_ELLIPSIS;
                  tok0.length = LenBits'(3);
                  tok0.first = ".";
                  mode_in = MODE_IDLE;
               end else begin flush_go = 1'b1; idle_go = 1'b1; end
            MODE_COLON1:
               if (c == ":") begin mode_in = MODE_COLON2; len_in = LenBits'(2); end
               else begin flush_go = 1'b1; idle_go = 1'b1; end
            MODE_COLON2:
               if (c == "=") begin
                  emit0 = 1'b1;
                  tok0.kind = KIND_ASSIGN;
                  tok0.length = LenBits'(3);
                  tok0.first = ":";
                  mode_in = MODE_IDLE;
               end else begin flush_go = 1'b1; idle_go = 1'b1; end
            default: idle_go = 1'b1;
         endcase
         if (flush_go && femit) emit0 = 1'b1;
         if (idle_go) begin
            mode_in = imode;
            if (iemit) begin
               if (flush_go && femit) begin
                  emit1 = 1'b1;
                  tok1  = itok;
               end else begin
                  emit0 = 1'b1;
                  tok0  = itok;
               end
            end
            if (imode != MODE_IDLE) begin
               tline_in = line_ff;
               tcol_in  = col_ff;
               first_in = (imode == MODE_STRING) ? 8'd0 : c;
               len_in   = (imode == MODE_IDENT || imode == MODE_NUMBER
                           || imode == MODE_STRING) ? LenBits'(0) : LenBits'(1);
               if (imode == MODE_IDENT || imode == MODE_NUMBER) app = 1'b1;
               if (imode == MODE_STRING) quote_in = (c == 8'h27);
            end
         end
         if (app) begin
            if (len_in == '0) first_in = c;
            if (len_in != '1) len_in = len_in + 1'b1;
         end
      end
   end

   assign wr_en = step && app && (len_in <= LenBits'(MAX_WORD_LEN)) && (len_in != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         line_ff  <= LINE_BITS'(1);
         col_ff   <= COLUMN_BITS'(1);
         tline_ff <= LINE_BITS'(1);
         tcol_ff  <= COLUMN_BITS'(1);
         len_ff   <= '0;
         first_ff <= '0;
         quote_ff <= 1'b0;
      end else if (step) begin
         mode_ff  <= mode_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         tline_ff <= tline_in;
         tcol_ff  <= tcol_in;
         len_ff   <= len_in;
         first_ff <= first_in;
         quote_ff <= quote_in;
      end
   end

   // store the appended byte at its old length position
   always_ff @(posedge clock) begin
      if (wr_en) word_ff[WIDX'(len_in - 1'b1)] <= c;
   end

   `ATS_ASSERT_IMPL(a_emit1_needs_emit0, clock, reset, emit1, emit0,
      "second token without first")
   `ATS_ASSERT_IMPL(a_eoi_emits, clock, reset, step && eoi, emit0,
      "end of input gave no token")
   `ATS_ASSERT_NEXT(a_eoi_idle, clock, reset, step && eoi, mode_ff == MODE_IDLE,
      "scanner not idle after end of input")
   `ATS_ASSERT_IMPL(a_line_nonzero, clock, reset, 1'b1, line_ff != '0,
      "line count reached zero")

endmodule

[rtl/core/asn1_token_scanner_top.sv]
// Token scanner for ASN.1 source text.
// req_: one source byte per beat; tdata = char_byte, tlast = end_of_input
//   (a zero byte also ends the input).
// rsp_: one token record per beat; tlast marks the last token of an input beat.
// Each input beat produces zero, one or two tokens; tokens are registered into
// the result queue when the input beat is taken and leave it in order.
// Throughput is one input beat per cycle while tokens average at most one per
// beat, set by the per-beat mode update and parallel keyword compare; the
// four-entry result queue keeps intake open while up to two tokens wait.
// When the receiver stalls, the queue fills and req_tready drops until there is
// room for two tokens again.
// Reset returns the scanner to idle, line and column to 1, and empties the queue.
// -----------------------------------------------------------------------------
// asn1_token_scanner_top
// Top level: input handshake, scanner core and result queue.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module asn1_token_scanner_top #(
   parameter int MAX_WORD_LEN = ats_pkg::MaxWordLenDefault,
   parameter int LINE_BITS    = ats_pkg::LineBitsDefault,
   parameter int COLUMN_BITS  = ats_pkg::ColumnBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [6:0] token_kind, [30:7] start_line, [46:31] start_column,
   // [62:47] token_length, [70:63] first_char, [71] zero
   output logic [71:0] rsp_tdata,
   output logic        rsp_tlast
);
   import ats_pkg::*;

   logic      step, emit0, emit1, space2, rsp_last;
   token_type tok0, tok1, rsp_tok;

   assign req_tready = space2;
   assign step       = req_tvalid && req_tready;

   ats_scan_core #(
      .MAX_WORD_LEN(MAX_WORD_LEN), .LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS)
   ) u_core (
      .clock(clock), .reset(reset), .step(step),
      .char_byte(req_tdata), .end_of_input(req_tlast),
      .emit0(emit0), .emit1(emit1), .tok0(tok0), .tok1(tok1)
   );

   ats_out_queue u_queue (
      .clock(clock), .reset(reset),
      .push0(step && emit0), .push1(step && emit1),
      .tok0(tok0), .tok1(tok1), .last0(!emit1),
      .space2(space2),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tok(rsp_tok), .rsp_last(rsp_last)
   );

   assign rsp_tdata = {1'b0, rsp_tok.first, rsp_tok.length, rsp_tok.column,
                       rsp_tok.line, rsp_tok.kind};
   assign rsp_tlast = rsp_last;

endmodule

[tb/asn1_token_scanner_top_test.sv]
// -----------------------------------------------------------------------------
// asn1_token_scanner_top_test
// Streams ASN.1-like source bytes into the token scanner and checks each token
// record, field by field, against a cycle-free software scanner kept in step
// with the accepted input beats.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module asn1_token_scanner_top_test;
   import ats_pkg::*;

   typedef struct {
      token_type tok;
      bit        last;
   } token_rec_type;

   class token_scoreboard;
      string kw_names[KwCount] = '{
         "SEQUENCE", "SET", "CHOICE", "OPTIONAL", "DEFAULT", "INTEGER", "BOOLEAN",
         "ENUMERATED", "OCTET", "BIT", "SIZE", "OF", "OBJECT", "DEFINITIONS",
         "BEGIN", "END", "IMPORTS", "FROM", "ANY", "DEFINED", "BY", "CLASS",
         "CONTAINING", "WITH", "COMPONENTS", "IMPLICIT", "EXPLICIT", "APPLICATION",
         "UNIVERSAL", "PRIVATE", "SYNTAX", "NULL", "REAL", "UTF8String",
         "PrintableString", "VisibleString", "IA5String", "NumericString",
         "AUTOMATIC", "TAGS", "EXTENSIBILITY", "IMPLIED"};
      mode_type      mode = MODE_IDLE;
      logic [23:0]   line = 1, tline = 1;
      logic [15:0]   col = 1, tcol = 1, tlen = 0;
      logic [7:0]    tfirst = 0;
      bit            single_quote = 0;
      logic [7:0]    word[MaxWordLenDefault];
      token_rec_type pending_tokens[$];
      token_rec_type step_out[$];
      int            errors = 0;

      function bit is_space(logic [7:0] c);
         return c == " " || (c >= 9 && c <= 13);
      endfunction
      function bit is_digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction
      function bit is_alpha(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      function void advance(logic [7:0] c);
         if (c == 8'h0a) begin
            if (line != '1) line++;
            col = 1;
         end else if (col != '1) col++;
      endfunction

      function void put(logic [6:0] k, logic [23:0] ln, logic [15:0] cl,
                        logic [15:0] len, logic [7:0] f);
         token_rec_type r;
         r.tok.kind = k; r.tok.line = ln; r.tok.column = cl;
         r.tok.length = len; r.tok.first = f; r.last = 0;
         step_out = {step_out, r};
      endfunction

      function void begin_token(mode_type m, logic [15:0] len, logic [7:0] f);
         mode = m; tline = line; tcol = col; tlen = len; tfirst = f;
      endfunction

      function void append(logic [7:0] c);
         if (tlen < MaxWordLenDefault) word[tlen] = c;
         if (tlen == 0) tfirst = c;
         if (tlen != '1) tlen++;
      endfunction

      function logic [6:0] word_kind();
         bit hit;
         if (tlen > MaxWordLenDefault) return KIND_IDENT;
         for (int i = 0; i < KwCount; i++) begin
            if (kw_names[i].len() == tlen) begin
               hit = 1;
               for (int k = 0; k < tlen; k++) if (word[k] != kw_names[i][k]) hit = 0;
               if (hit) return KIND_KW_BASE + 7'(i);
            end
         end
         return KIND_IDENT;
      endfunction

      function void close_token();
         logic [6:0] k;
         case (mode)
            MODE_IDENT:  k = word_kind();
            MODE_NUMBER: k = KIND_NUMBER;
            MODE_STRING: k = KIND_STRING;
            MODE_DASH:   k = KIND_MINUS;
            MODE_LBRACK: k = KIND_LBRACK;
            MODE_RBRACK: k = KIND_RBRACK;
            MODE_DOT1:   k = KIND_DOT;
            MODE_DOT2:   k = KIND_RANGE;
            MODE_COLON1, MODE_COLON2: k = KIND_UNKNOWN;
            default: begin
               mode = MODE_IDLE;
               return;
            end
         endcase
         put(k, tline, tcol, tlen, tfirst);
         mode = MODE_IDLE;
      endfunction

      function void from_idle(logic [7:0] c);
         logic [6:0] k;
         mode = MODE_IDLE;
         if (is_space(c)) begin
            advance(c);
            return;
         end
         if (is_alpha(c) || c == "_") begin
            begin_token(MODE_IDENT, 0, c); append(c); advance(c);
            return;
         end
         if (is_digit(c)) begin
            begin_token(MODE_NUMBER, 0, c); append(c); advance(c);
            return;
         end
         if (c == "\"" || c == "'") begin
            begin_token(MODE_STRING, 0, 0);
            single_quote = (c == "'");
            advance(c);
            return;
         end
         case (c)
            "-": begin begin_token(MODE_DASH, 1, c); advance(c); return; end
            "[": begin begin_token(MODE_LBRACK, 1, c); advance(c); return; end
            "]": begin begin_token(MODE_RBRACK, 1, c); advance(c); return; end
            ".": begin begin_token(MODE_DOT1, 1, c); advance(c); return; end
            ":": begin begin_token(MODE_COLON1, 1, c); advance(c); return; end
            "(": k = KIND_LPAREN;
            ")": k = KIND_RPAREN;
            "{": k = KIND_LBRACE;
            "}": k = KIND_RBRACE;
            ",": k = KIND_COMMA;
            "|": k = KIND_BAR;
            "&": k = KIND_AMP;
            "@": k = KIND_AT;
            ";": k = KIND_SEMI;
            "+": k = KIND_PLUS;
            default: k = KIND_UNKNOWN;
         endcase
         put(k, line, col, 1, c);
         advance(c);
      endfunction

      function void note_beat(logic [7:0] c, logic eoi);
         step_out.delete();
         if (eoi || c == 0) begin
            close_token();
            put(KIND_EOF, line, col, 0, 0);
            mode = MODE_IDLE;
         end else begin
            case (mode)
               MODE_IDENT:
                  if (is_alpha(c) || is_digit(c) || c == "_" || c == "-") begin
                     append(c); advance(c);
                  end else begin close_token(); from_idle(c); end
               MODE_NUMBER:
                  if (is_digit(c)) begin append(c); advance(c); end
                  else begin close_token(); from_idle(c); end
               MODE_STRING:
                  if (c == (single_quote ? 8'h27 : 8'h22)) begin
                     close_token(); advance(c);
                  end else begin append(c); advance(c); end
               MODE_COMMENT: begin
                  advance(c);
                  if (c == 8'h0a) mode = MODE_IDLE;
               end
               MODE_DASH:
                  if (c == "-") begin mode = MODE_COMMENT; advance(c); end
                  else begin close_token(); from_idle(c); end
               MODE_LBRACK, MODE_RBRACK:
                  if (c == (mode == MODE_LBRACK ? 8'h5b : 8'h5d)) begin
                     put(mode == MODE_LBRACK ? KIND_DLBRACK : KIND_DRBRACK,
                         tline, tcol, 2, c);
                     advance(c);
                     mode = MODE_IDLE;
                  end else begin close_token(); from_idle(c); end
               MODE_DOT1:
                  if (c == ".") begin mode = MODE_DOT2; tlen = 2; advance(c); end
                  else begin close_token(); from_idle(c); end
               MODE_DOT2:
                  if (c == ".") begin
                     put(KIND_ELLIPSIS, tline, tcol, 3, ".");
                     advance(c);
                     mode = MODE_IDLE;
                  end else begin close_token(); from_idle(c); end
               MODE_COLON1:
                  if (c == ":") begin mode = MODE_COLON2; tlen = 2; advance(c); end
                  else begin close_token(); from_idle(c); end
               MODE_COLON2:
                  if (c == "=") begin
                     put(KIND_ASSIGN, tline, tcol, 3, ":");
                     advance(c);
                     mode = MODE_IDLE;
                  end else begin close_token(); from_idle(c); end
               default: from_idle(c);
            endcase
         end
         if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1;
         foreach (step_out[i]) pending_tokens = {pending_tokens, step_out[i]};
      endfunction

      function void check_token(logic [71:0] d, logic l);
         token_rec_type e;
         token_type got;
         got.kind = d[6:0]; got.line = d[30:7]; got.column = d[46:31];
         got.length = d[62:47]; got.first = d[70:63];
         if (pending_tokens.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected token %h last=%b", d, l);
            return;
         end
         e = pending_tokens.pop_front();
         if (got !== e.tok || l !== e.last || d[71] !== 1'b0) begin
            errors++;
            if (errors <= 10) begin
               $display("token mismatch: exp kind=%0d line=%0d col=%0d len=%0d first=%h last=%b",
                        e.tok.kind, e.tok.line, e.tok.column, e.tok.length, e.tok.first,
                        e.last);
               $display("                got kind=%0d line=%0d col=%0d len=%0d first=%h last=%b",
                        got.kind, got.line, got.column, got.length, got.first, l);
            end
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset;
   logic        req_tvalid, req_tlast, rsp_tready;
   logic [7:0]  req_tdata;
   logic        req_tready, rsp_tvalid, rsp_tlast;
   logic [71:0] rsp_tdata;

   token_scoreboard sb = new();
   bit          quiet = 0;
   longint      cycles = 0;
   int          sent = 0;

   asn1_token_scanner_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && req_tvalid && req_tready) sb.note_beat(req_tdata, req_tlast);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_token(rsp_tdata, rsp_tlast);
      if (cycles > 3000000) begin
         $display("[asn1_token_scanner_top] ERROR");
         $finish;
      end
   end

   // receiver: random stalls, one long hold-off while the sender keeps going
   initial begin
      int n;
      rsp_tready <= 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      repeat (300) begin
         rsp_tready <= 1;
         @(posedge clock);
      end
      rsp_tready <= 0;
      repeat (400) @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 0;
            n = $urandom_range(1, 17);
         end else begin
            rsp_tready <= 1;
            n = $urandom_range(1, 30);
         end
         repeat (n) @(posedge clock);
      end
   end

   task automatic send_beat(logic [7:0] c, logic eoi);
      if (!quiet && $urandom_range(0, 11) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= c;
      req_tlast <= eoi;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], 0);
   endtask

   task automatic send_fragment();
      string s;
      string ops = "(){},|&@;+.:[]-";
      int n;
      case ($urandom_range(0, 15))
         0, 1: send_text(sb.kw_names[$urandom_range(0, KwCount - 1)]);
         2, 3: begin
            n = $urandom_range(1, 20);
            s = "";
            for (int i = 0; i < n; i++)
               case ($urandom_range(0, 4))
                  0: s = {s, string'(8'($urandom_range("a", "z")))};
                  1: s = {s, string'(8'($urandom_range("A", "Z")))};
                  2: s = {s, string'(8'($urandom_range("0", "9")))};
                  3: s = {s, "_"};
                  default: s = {s, "-"};
               endcase
            send_beat($urandom_range(0, 1) ? "_" : 8'($urandom_range("a", "z")), 0);
            send_text(s);
         end
         4: begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) send_beat(8'($urandom_range("0", "9")), 0);
         end
         5: begin
            s = $urandom_range(0, 1) ? "\"" : "'";
            send_text(s);
            repeat ($urandom_range(0, 6)) send_beat(8'($urandom_range(1, 255)), 0);
            send_text(s);
         end
         6: begin
            send_text("--");
            repeat ($urandom_range(0, 6)) send_beat(8'($urandom_range(1, 255)), 0);
            send_beat(8'h0a, 0);
         end
         7: case ($urandom_range(0, 8))
               0: send_text("::=");
               1: send_text("...");
               2: send_text("..");
               3: send_text("[[");
               4: send_text("]]");
               5: send_text("::");
               6: send_text("-");
               7: send_text("[");
               default: send_text("]");
            endcase
         8: send_beat(ops[$urandom_range(0, ops.len() - 1)], 0);
         9, 10: send_beat(" ", 0);
         11: send_beat(8'($urandom_range(9, 13)), 0);
         12: send_beat(8'h0a, 0);
         13: send_beat(8'($urandom_range(1, 255)), 0);
         14: send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         default: send_beat(8'($urandom_range(0, 255)), 1);
      endcase
   endtask

   initial begin
      reset <= 1;
      req_tvalid <= 0;
      req_tdata <= 0;
      req_tlast <= 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_text("SEQUENCE ::= { a-b--c, 12 }\n");
      send_text("PrintableString ABCDEFGHIJKLMNOPQ [[x]] ...y.. :: : . ");
      send_text("\"\" 'it' --note\n");
      send_beat(8'hff, 0);
      send_beat(8'h80, 0);
      send_text("\"open");
      send_beat(8'h00, 0);
      send_text("zz");
      send_beat(8'h41, 1);

      while (sent < 1200) send_fragment();

      // tail without idling: one long word past the keyword buffer
      quiet = 1;
      send_beat(8'h0a, 0);
      repeat (40) send_beat("q", 0);
      send_text(" + 7");
      send_beat(8'h00, 1);
      send_text("\nEND");
      send_beat(8'h00, 1);
      req_tvalid <= 0;

      while (sb.pending_tokens.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0)
         $display("[asn1_token_scanner_top] OK");
      else
         $display("[asn1_token_scanner_top] ERROR");
      $finish;
   end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/ats_pkg.sv
rtl/core/ats_kw_match.sv
rtl/core/ats_out_queue.sv
rtl/core/ats_scan_core.sv
rtl/core/asn1_token_scanner_top.sv
tb/asn1_token_scanner_top_test.sv
